// ===== hw/rtl/swq_pkg.sv =====
// ---------------------------------------------------------------------------
// swq_pkg
// Shared types and constants for the semaphore wait queue engine: field
// widths, operation codes, memory entry layout and the sequencer states.
// ---------------------------------------------------------------------------
package swq_pkg;

  // field widths fixed by the transaction format
  localparam int ACT_W    = 3;
  localparam int SEM_W    = 4;
  localparam int THREAD_W = 5;
  localparam int VAL_W    = 16;

  // default sizes
  localparam int NUM_SEMAPHORES_DEF = 16;
  localparam int MAX_THREADS_DEF    = 32;

  // operation codes
  localparam logic [ACT_W-1:0] ACT_INIT    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WAIT    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_BWAIT   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SIGNAL  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_BSIGNAL = 3'd4;

  // special semaphore values
  localparam logic [VAL_W-1:0] VAL_MAX       = 16'h7FFF;
  localparam logic [VAL_W-1:0] VAL_MINUS_ONE = 16'hFFFF;
  localparam logic [VAL_W-1:0] VAL_ZERO      = 16'h0000;

  // one semaphore memory entry
  typedef struct packed {
    logic [VAL_W-1:0]    value;
    logic [THREAD_W-1:0] head;
    logic [THREAD_W-1:0] tail;
  } sem_entry_t;

  localparam int SEM_ENTRY_W = $bits(sem_entry_t);

  // state writes produced by one operation
  typedef struct packed {
    logic                sem_we;
    sem_entry_t          sem_wdata;
    logic                ne_we;
    logic                ne_val;
    logic                link_we;
    logic [THREAD_W-1:0] link_waddr;
    logic [THREAD_W-1:0] link_wdata;
    logic                blk_set;
    logic                blk_clr;
    logic [THREAD_W-1:0] blk_id;
  } upd_t;

  // result transaction
  typedef struct packed {
    logic                caller_blocked;
    logic                woken_valid;
    logic [THREAD_W-1:0] woken_thread;
    logic [VAL_W-1:0]    value_after;
  } res_t;

  // operation sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_EXEC
  } state_t;

endpackage

// ===== hw/rtl/swq_ram.sv =====
// ---------------------------------------------------------------------------
// swq_ram
// Generic single write port, single read port RAM with registered read data
// and a read enable that holds the last read word.
// ---------------------------------------------------------------------------
module swq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/swq_update.sv =====
// ---------------------------------------------------------------------------
// swq_update
// Modify step of the read-modify-write: from the semaphore entry, the queue
// state and the head's link it forms the memory writes and the result.
// ---------------------------------------------------------------------------
module swq_update
  import swq_pkg::*;
(
  input  logic [ACT_W-1:0]    action,
  input  logic [THREAD_W-1:0] caller,
  input  logic [VAL_W-1:0]    init_value,
  input  logic                sem_ok,
  input  logic                caller_ok,
  input  logic                caller_blk,
  input  sem_entry_t          cur,
  input  logic                nonempty,
  input  logic [THREAD_W-1:0] head_link,
  output upd_t                upd,
  output res_t                res
);

  logic [VAL_W-1:0]    v;
  logic [THREAD_W-1:0] head_n;
  logic [THREAD_W-1:0] tail_n;

  // operation decode and state update
  always_comb begin
    v      = cur.value;
    head_n = cur.head;
    tail_n = cur.tail;
    upd    = '0;
    res    = '0;
    case (action)
      ACT_INIT: begin
        v          = init_value;
        upd.ne_we  = 1'b1;
        upd.ne_val = 1'b0;
      end
      ACT_WAIT, ACT_BWAIT: begin
        if (caller_ok && !caller_blk) begin
          if (v[VAL_W-1]) begin
            // append caller at the tail
            res.caller_blocked = 1'b1;
            upd.blk_set        = 1'b1;
            upd.blk_id         = caller;
            if (nonempty) begin
              upd.link_we    = 1'b1;
              upd.link_waddr = cur.tail;
              upd.link_wdata = caller;
            end else begin
              head_n     = caller;
              upd.ne_we  = 1'b1;
              upd.ne_val = 1'b1;
            end
            tail_n = caller;
          end else if (action == ACT_WAIT) begin
            v = v - 1'b1;
          end
          if (action == ACT_BWAIT) begin
            v = VAL_MINUS_ONE;
          end
        end
      end
      ACT_SIGNAL, ACT_BSIGNAL: begin
        if (nonempty) begin
          // release the head
          res.woken_valid  = 1'b1;
          res.woken_thread = cur.head;
          upd.blk_clr      = 1'b1;
          upd.blk_id       = cur.head;
          if (cur.head == cur.tail) begin
            upd.ne_we  = 1'b1;
            upd.ne_val = 1'b0;
          end else begin
            head_n = head_link;
          end
          if (action == ACT_BSIGNAL) begin
            v = VAL_MINUS_ONE;
          end
        end else if (action == ACT_BSIGNAL) begin
          v = VAL_ZERO;
        end else if (v != VAL_MAX) begin
          v = v + 1'b1;
        end
      end
      default: begin
      end
    endcase

    upd.sem_we          = 1'b1;
    upd.sem_wdata.value = v;
    upd.sem_wdata.head  = head_n;
    upd.sem_wdata.tail  = tail_n;
    res.value_after     = v;

    // out-of-range semaphore: no effect, all-zero result
    if (!sem_ok) begin
      upd = '0;
      res = '0;
    end
  end

endmodule

// ===== hw/rtl/semaphore_wait_queue_engine.sv =====
// ---------------------------------------------------------------------------
// semaphore_wait_queue_engine
// Sequence: semaphore memory read on acceptance, then link memory read in
// ST_LINK, then execute and write back in ST_EXEC, where a stalled output
// can hold it; a new operation is accepted only in ST_IDLE.
// The output register lets the next operation be accepted while a result waits.
// Reset clears sequencer, value-valid, queue-nonempty and blocked flags; no
// clearing pass is needed.
// ---------------------------------------------------------------------------
module semaphore_wait_queue_engine
  import swq_pkg::*;
#(
  parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
  parameter int MAX_THREADS    = MAX_THREADS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ACT_W-1:0]        in_action,
  input  logic [SEM_W-1:0]        in_sem_index,
  input  logic [THREAD_W-1:0]     in_caller_thread,
  input  logic signed [VAL_W-1:0] in_init_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_caller_blocked,
  output logic                    out_woken_valid,
  output logic [THREAD_W-1:0]     out_woken_thread,
  output logic signed [VAL_W-1:0] out_value_after
);

  localparam int SAW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int TAW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

  state_t state_r, state_nxt;

  // latched transaction
  logic [ACT_W-1:0]    act_r;
  logic [SEM_W-1:0]    sem_r;
  logic [THREAD_W-1:0] thr_r;
  logic [VAL_W-1:0]    ival_r;

  // flag arrays
  logic [NUM_SEMAPHORES-1:0] sem_vld_r, sem_vld_nxt;
  logic [NUM_SEMAPHORES-1:0] ne_r, ne_nxt;
  logic [MAX_THREADS-1:0]    blk_r, blk_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  // control
  logic accept;
  logic link_re;
  logic exec_go;

  // address formation
  logic [SAW+SEM_W-1:0]    in_sem_ext, sem_ext;
  logic [SAW-1:0]          in_saddr, saddr;
  logic [TAW+THREAD_W-1:0] thr_ext, head_ext, link_ext, blk_ext;
  logic [TAW-1:0]          taddr, head_addr, link_waddr, blk_addr;

  logic       sem_ok, caller_ok;
  sem_entry_t sem_rd, cur;
  logic [THREAD_W-1:0] link_rd;
  upd_t upd;
  res_t res;

  assign in_sem_ext = {{SAW{1'b0}}, in_sem_index};
  assign in_saddr   = in_sem_ext[SAW-1:0];
  assign sem_ext    = {{SAW{1'b0}}, sem_r};
  assign saddr      = sem_ext[SAW-1:0];
  assign thr_ext    = {{TAW{1'b0}}, thr_r};
  assign taddr      = thr_ext[TAW-1:0];
  assign head_ext   = {{TAW{1'b0}}, sem_rd.head};
  assign head_addr  = head_ext[TAW-1:0];
  assign link_ext   = {{TAW{1'b0}}, upd.link_waddr};
  assign link_waddr = link_ext[TAW-1:0];
  assign blk_ext    = {{TAW{1'b0}}, upd.blk_id};
  assign blk_addr   = blk_ext[TAW-1:0];

  assign sem_ok    = (32'(sem_r) < NUM_SEMAPHORES);
  assign caller_ok = (32'(thr_r) < MAX_THREADS);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LINK;
        end
      end
      ST_LINK: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    link_re  = 1'b0;
    exec_go  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_LINK: begin
        link_re = 1'b1;
      end
      ST_EXEC: begin
        exec_go = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_action;
      sem_r  <= in_sem_index;
      thr_r  <= in_caller_thread;
      ival_r <= in_init_value;
    end
  end

  // semaphore memory: value, head, tail
  swq_ram #(
    .WIDTH (SEM_ENTRY_W),
    .DEPTH (NUM_SEMAPHORES),
    .AW    (SAW)
  ) u_sem_ram (
    .clk   (clk),
    .we    (exec_go && upd.sem_we),
    .waddr (saddr),
    .wdata (upd.sem_wdata),
    .re    (accept),
    .raddr (in_saddr),
    .rdata (sem_rd)
  );

  // thread link memory
  swq_ram #(
    .WIDTH (THREAD_W),
    .DEPTH (MAX_THREADS),
    .AW    (TAW)
  ) u_link_ram (
    .clk   (clk),
    .we    (exec_go && upd.link_we),
    .waddr (link_waddr),
    .wdata (upd.link_wdata),
    .re    (link_re),
    .raddr (head_addr),
    .rdata (link_rd)
  );

  // an unwritten semaphore value reads as zero
  always_comb begin
    cur = sem_rd;
    if (!sem_ok || !sem_vld_r[saddr]) begin
      cur.value = VAL_ZERO;
    end
  end

  swq_update u_update (
    .action     (act_r),
    .caller     (thr_r),
    .init_value (ival_r),
    .sem_ok     (sem_ok),
    .caller_ok  (caller_ok),
    .caller_blk (caller_ok && blk_r[taddr]),
    .cur        (cur),
    .nonempty   (sem_ok && ne_r[saddr]),
    .head_link  (link_rd),
    .upd        (upd),
    .res        (res)
  );

  // flag array updates
  always_comb begin
    sem_vld_nxt = sem_vld_r;
    ne_nxt      = ne_r;
    blk_nxt     = blk_r;
    if (exec_go) begin
      if (upd.sem_we) begin
        sem_vld_nxt[saddr] = 1'b1;
      end
      if (upd.ne_we) begin
        ne_nxt[saddr] = upd.ne_val;
      end
      if (upd.blk_set) begin
        blk_nxt[blk_addr] = 1'b1;
      end
      if (upd.blk_clr) begin
        blk_nxt[blk_addr] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sem_vld_r <= '0;
      ne_r      <= '0;
      blk_r     <= '0;
    end else begin
      sem_vld_r <= sem_vld_nxt;
      ne_r      <= ne_nxt;
      blk_r     <= blk_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_caller_blocked = res_r.caller_blocked;
  assign out_woken_valid    = res_r.woken_valid;
  assign out_woken_thread   = res_r.woken_thread;
  assign out_value_after    = res_r.value_after;

endmodule

// ===== test/semaphore_wait_queue_checker.sv =====
// ---------------------------------------------------------------------------
// semaphore_wait_queue_checker
// Watches the operation and result channels of the semaphore engine. It keeps
// its own copy of the semaphore values, wait queues and blocked flags, works
// out the outcome of each accepted operation, and compares every accepted
// result against the oldest outcome still owed.
// ---------------------------------------------------------------------------
module semaphore_wait_queue_checker
  import swq_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [ACT_W-1:0]                  in_action,
  input  logic [SEM_W-1:0]                  in_sem_index,
  input  logic [THREAD_W-1:0]               in_caller_thread,
  input  logic signed [VAL_W-1:0]           in_init_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              out_caller_blocked,
  input  logic                              out_woken_valid,
  input  logic [THREAD_W-1:0]               out_woken_thread,
  input  logic signed [VAL_W-1:0]           out_value_after,
  output int                                mismatch_count,
  output int                                outcomes_owed,
  output logic [MAX_THREADS_DEF-1:0]        blocked_threads,
  output logic [NUM_SEMAPHORES_DEF-1:0]     queued_sems
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // shadow semaphore state
  logic [VAL_W-1:0]    sem_val  [NUM_SEMAPHORES_DEF];
  logic [THREAD_W-1:0] q_head   [NUM_SEMAPHORES_DEF];
  logic [THREAD_W-1:0] q_tail   [NUM_SEMAPHORES_DEF];
  logic [THREAD_W-1:0] thr_link [MAX_THREADS_DEF];

  // outcomes of accepted operations, oldest first
  res_t op_outcomes[$];

  // apply one operation to the shadow state and return its outcome
  function automatic res_t run_sem_op(input logic [ACT_W-1:0]    act,
                                      input logic [SEM_W-1:0]    sem,
                                      input logic [THREAD_W-1:0] thr,
                                      input logic [VAL_W-1:0]    ival);
    res_t                r;
    logic [VAL_W-1:0]    val;
    logic [THREAD_W-1:0] h;
    r   = '0;
    val = sem_val[sem];
    case (act)
      ACT_INIT: begin
        // waiters are dropped but stay blocked
        val               = ival;
        queued_sems[sem]  = 1'b0;
      end
      ACT_WAIT, ACT_BWAIT: begin
        // a blocked thread cannot issue a wait
        if (!blocked_threads[thr]) begin
          if (val[VAL_W-1]) begin
            if (queued_sems[sem]) begin
              thr_link[q_tail[sem]] = thr;
            end else begin
              q_head[sem]      = thr;
              queued_sems[sem] = 1'b1;
            end
            q_tail[sem]          = thr;
            blocked_threads[thr] = 1'b1;
            r.caller_blocked     = 1'b1;
          end else if (act == ACT_WAIT) begin
            val = val - 1'b1;
          end
          if (act == ACT_BWAIT) begin
            val = VAL_MINUS_ONE;
          end
        end
      end
      ACT_SIGNAL, ACT_BSIGNAL: begin
        if (queued_sems[sem]) begin
          // release the oldest waiter
          h = q_head[sem];
          if (h == q_tail[sem]) begin
            queued_sems[sem] = 1'b0;
          end else begin
            q_head[sem] = thr_link[h];
          end
          blocked_threads[h] = 1'b0;
          r.woken_valid      = 1'b1;
          r.woken_thread     = h;
          if (act == ACT_BSIGNAL) begin
            val = VAL_MINUS_ONE;
          end
        end else if (act == ACT_BSIGNAL) begin
          val = VAL_ZERO;
        end else if (val != VAL_MAX) begin
          val = val + 1'b1;
        end
      end
      default: begin
        // spare codes leave everything alone
      end
    endcase
    sem_val[sem]  = val;
    r.value_after = val;
    return r;
  endfunction

  // compare results, then record the outcome of a new operation
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEMAPHORES_DEF; i++) begin
        sem_val[i] = VAL_ZERO;
      end
      queued_sems     = '0;
      blocked_threads = '0;
      mismatch_count  = 0;
      op_outcomes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (op_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: result with no operation owed: blocked=%0b woken=%0b/%0d value=%0d",
                     $realtime, out_caller_blocked, out_woken_valid, out_woken_thread,
                     out_value_after);
          end
        end else begin
          want = op_outcomes.pop_front();
          if (out_caller_blocked !== want.caller_blocked ||
              out_woken_valid !== want.woken_valid ||
              out_woken_thread !== want.woken_thread ||
              out_value_after !== want.value_after) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("%0t: result mismatch: exp blocked=%0b woken=%0b/%0d value=%0d",
                       $realtime, want.caller_blocked, want.woken_valid,
                       want.woken_thread, $signed(want.value_after));
              $display("%0t:                  got blocked=%0b woken=%0b/%0d value=%0d",
                       $realtime, out_caller_blocked, out_woken_valid,
                       out_woken_thread, out_value_after);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        op_outcomes.push_back(run_sem_op(in_action, in_sem_index, in_caller_thread,
                                         in_init_value));
      end
    end
    outcomes_owed <= op_outcomes.size();
  end

endmodule

// ===== test/semaphore_wait_queue_engine_tb.sv =====
// ---------------------------------------------------------------------------
// semaphore_wait_queue_engine_tb
// Drives semaphore operations into the engine: a directed opening over the
// value extremes, every operation and the corner cases, then phases of random
// wait and signal traffic, mostly on one to three semaphores, so that wait
// queues grow and drain. Both channels idle in random bursts; the checker
// beside the engine decides whether every result is right.
// ---------------------------------------------------------------------------
module semaphore_wait_queue_engine_tb
  import swq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 550;
  localparam int CALM_ITEMS     = 80;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int STRAND_BUDGET  = 2;

  localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;
  localparam logic [VAL_W-1:0] VAL_MOST_NEG    = 16'h8000;

  logic                    clk;
  logic                    rst_n            = 1'b0;
  logic                    in_valid         = 1'b0;
  logic                    in_stall;
  logic [ACT_W-1:0]        in_action        = ACT_INIT;
  logic [SEM_W-1:0]        in_sem_index     = '0;
  logic [THREAD_W-1:0]     in_caller_thread = '0;
  logic signed [VAL_W-1:0] in_init_value    = '0;
  logic                    out_valid;
  logic                    out_stall        = 1'b0;
  logic                    out_caller_blocked;
  logic                    out_woken_valid;
  logic [THREAD_W-1:0]     out_woken_thread;
  logic signed [VAL_W-1:0] out_value_after;

  int                            mismatch_count;
  int                            outcomes_owed;
  logic [MAX_THREADS_DEF-1:0]    blocked_threads;
  logic [NUM_SEMAPHORES_DEF-1:0] queued_sems;

  bit gaps_on       = 1'b1;
  bit stall_bursts  = 1'b1;
  bit hold_request  = 1'b0;
  int quiet_cycles  = 0;

  semaphore_wait_queue_engine dut (.*);

  semaphore_wait_queue_checker ops_check (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAIL semaphore_wait_queue_engine");
    $finish;
  end

  // result side back pressure: random bursts and one long hold
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one operation and hold it until accepted
  task automatic issue_op(input logic [ACT_W-1:0]    act,
                          input logic [SEM_W-1:0]    sem,
                          input logic [THREAD_W-1:0] thr,
                          input logic [VAL_W-1:0]    ival);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_sem_index     <= sem;
    in_caller_thread <= thr;
    in_init_value    <= ival;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering until every result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outcomes_owed != 0) @(posedge clk);
  endtask

  // a thread that is free to run, if there is one
  function automatic logic [THREAD_W-1:0] pick_runner();
    int idle_ids[$];
    for (int t = 0; t < MAX_THREADS_DEF; t++) begin
      if (!blocked_threads[t]) idle_ids.push_back(t);
    end
    if (idle_ids.size() == 0) return THREAD_W'($urandom_range(0, MAX_THREADS_DEF - 1));
    return THREAD_W'(idle_ids[$urandom_range(0, idle_ids.size() - 1)]);
  endfunction

  // mostly small values around zero, sometimes extremes or anything
  function automatic logic [VAL_W-1:0] pick_init_value();
    int near_zero;
    near_zero = int'($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MOST_NEG;
      2, 3:    return VAL_W'($urandom);
      default: return near_zero[VAL_W-1:0];
    endcase
  endfunction

  // stimulus and verdict
  initial begin
    int                  random_items;
    int                  phase;
    int                  n_focus;
    int                  phase_len;
    int                  wait_weight;
    int                  strands_left;
    int                  pick;
    logic [SEM_W-1:0]    focus [NUM_SEMAPHORES_DEF];
    logic [ACT_W-1:0]    act;
    logic [SEM_W-1:0]    sem;
    logic [THREAD_W-1:0] thr;

    random_items = 0;
    phase        = 0;
    strands_left = STRAND_BUDGET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: saturation, most negative value, queue order, bad callers
    issue_op(ACT_SIGNAL, 4'd0, 5'd0, 16'h0000);
    issue_op(ACT_INIT, 4'd1, 5'd31, VAL_MAX);
    issue_op(ACT_SIGNAL, 4'd1, 5'd0, 16'hFFFF);
    issue_op(ACT_INIT, 4'd2, 5'd0, VAL_MOST_NEG);
    issue_op(ACT_WAIT, 4'd2, 5'd0, 16'h0000);
    issue_op(ACT_BWAIT, 4'd2, 5'd31, 16'hFFFF);
    issue_op(ACT_WAIT, 4'd3, 5'd0, 16'h0000);
    issue_op(ACT_SIGNAL, 4'd2, 5'd7, 16'h0000);
    issue_op(ACT_BSIGNAL, 4'd2, 5'd7, 16'h0000);
    issue_op(ACT_BSIGNAL, 4'd2, 5'd7, 16'h0000);
    // init with a waiter leaves that thread blocked for good
    issue_op(ACT_BWAIT, 4'd15, 5'd5, 16'h0000);
    issue_op(ACT_BWAIT, 4'd15, 5'd6, 16'h0000);
    issue_op(ACT_INIT, 4'd15, 5'd0, 16'h5555);
    issue_op(ACT_WAIT, 4'd4, 5'd6, 16'h0000);
    issue_op(ACT_SIGNAL, 4'd15, 5'd0, 16'h0000);
    // spare action codes
    issue_op(ACT_SPARE_FIRST, 4'd7, 5'd31, 16'hFFFF);
    issue_op(ACT_SPARE_FIRST + 1'b1, 4'd8, 5'd31, 16'hFFFF);
    issue_op(ACT_SPARE_LAST, 4'd15, 5'd31, 16'hFFFF);
    // count down through zero, then a binary signal to a waiter
    issue_op(ACT_WAIT, 4'd0, 5'd1, 16'h0000);
    issue_op(ACT_WAIT, 4'd0, 5'd2, 16'h0000);
    issue_op(ACT_WAIT, 4'd0, 5'd3, 16'h0000);
    issue_op(ACT_BSIGNAL, 4'd0, 5'd0, 16'h0000);
    issue_op(ACT_INIT, 4'd9, 5'd0, 16'hAAAA);
    issue_op(ACT_BSIGNAL, 4'd9, 5'd0, 16'h0000);

    // random phases, each starting from a drained engine
    while (random_items < RANDOM_ITEMS) begin
      wait_drained();
      if (random_items >= RANDOM_ITEMS - CALM_ITEMS) begin
        gaps_on      = 1'b0;
        stall_bursts = 1'b0;
      end else begin
        gaps_on      = ($urandom_range(0, 3) != 0);
        stall_bursts = ($urandom_range(0, 3) != 0);
      end
      if (phase == 2) hold_request = 1'b1;

      // pick the semaphores this phase works on
      n_focus = ($urandom_range(0, 4) == 0) ? NUM_SEMAPHORES_DEF : $urandom_range(1, 3);
      for (int i = 0; i < n_focus; i++) begin
        focus[i] = (n_focus == NUM_SEMAPHORES_DEF) ? SEM_W'(i)
                                                   : SEM_W'($urandom_range(0, 15));
      end

      // fresh values; queues with waiters are kept except on rare occasions
      for (int i = 0; i < n_focus; i++) begin
        if (!queued_sems[focus[i]] || (strands_left > 0 && $urandom_range(0, 7) == 0)) begin
          if (queued_sems[focus[i]]) strands_left--;
          issue_op(ACT_INIT, focus[i], THREAD_W'($urandom_range(0, MAX_THREADS_DEF - 1)),
                   pick_init_value());
          random_items++;
        end
      end

      // waits, signals and occasional spare codes with random content
      wait_weight = $urandom_range(35, 65);
      phase_len   = $urandom_range(20, 60);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        sem  = ($urandom_range(0, 9) != 0) ? focus[$urandom_range(0, n_focus - 1)]
                                            : SEM_W'($urandom_range(0, NUM_SEMAPHORES_DEF - 1));
        thr  = THREAD_W'($urandom_range(0, MAX_THREADS_DEF - 1));
        if (pick < wait_weight) begin
          act = ($urandom_range(0, 3) == 0) ? ACT_BWAIT : ACT_WAIT;
          if ($urandom_range(0, 19) != 0) thr = pick_runner();
        end else if (pick < 97) begin
          act = ($urandom_range(0, 3) == 0) ? ACT_BSIGNAL : ACT_SIGNAL;
        end else begin
          act = ACT_W'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
        end
        issue_op(act, sem, thr, VAL_W'($urandom));
        random_items++;
      end
      phase++;
    end

    // let the last results come back
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS semaphore_wait_queue_engine");
    end else begin
      $display("FAIL semaphore_wait_queue_engine");
    end
    $finish;
  end

endmodule
